// ===== rtl/rpzp_pkg.sv =====
// Package: shared constants, types and command/status structs for the point plotter
`timescale 1ns / 1ps
package rpzp_pkg;
  localparam int ScreenWidth  = 320;
  localparam int ScreenHeight = 240;
  localparam int FractionBits = 14;
  localparam int PixelCount   = ScreenWidth * ScreenHeight;
  localparam int AddrW        = $clog2(PixelCount);
  localparam logic signed [15:0] PerspBase  = 16'sd880;
  localparam int                 PerspShift = 11;
  localparam logic signed [15:0] DepthClear = 16'sd32767;

  localparam logic [1:0] REG_ROW_X = 2'd0;
  localparam logic [1:0] REG_ROW_Y = 2'd1;
  localparam logic [1:0] REG_ROW_Z = 2'd2;
  localparam logic [1:0] REG_MODE  = 2'd3;

  localparam logic KIND_PLOT  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word
    logic rot;        // rotation products -> sums
    logic proj;       // projection products
    logic place;      // screen position and address
    logic rd;         // depth memory read
    logic wr_test;    // depth compare and write, load output
    logic clr_start;  // reset sweep counter
    logic clr_step;   // write one clear entry
    logic out_take;   // output word taken
  } rpzp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_clear;
    logic clr_last;
    logic out_full;
  } rpzp_sts_t;
endpackage

// ===== rtl/rpzp_datapath.sv =====
// Datapath: rotation, projection, depth memory and output register
`timescale 1ns / 1ps
module rpzp_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rpzp_pkg::rpzp_cmd_t        cmd,
  output rpzp_pkg::rpzp_sts_t        sts,
  input  logic                       in_kind,
  input  logic signed [15:0]         in_point_x,
  input  logic signed [15:0]         in_point_y,
  input  logic signed [15:0]         in_point_z,
  input  logic [15:0]                in_point_color,
  input  logic [47:0]                row_x,
  input  logic [47:0]                row_y,
  input  logic [47:0]                row_z,
  input  logic                       iso_mode,
  output logic                       out_valid,
  output logic [16:0]                out_pixel_address,
  output logic [15:0]                out_pixel_color,
  output logic signed [15:0]         out_pixel_depth
);
  localparam int AW = rpzp_pkg::AddrW;

  logic                kind_r;
  logic signed [15:0]  px_r, py_r, pz_r;
  logic [15:0]         color_r;
  logic signed [15:0]  rx_r, ry_r, rz_r;
  logic signed [15:0]  sx_r, sy_r;
  logic                onscr_r;
  logic [AW-1:0]       addr_r;
  logic signed [15:0]  mem_q_r;
  logic [AW-1:0]       clr_cnt_r;
  logic                ovld_r;
  logic [16:0]         oaddr_r;
  logic [15:0]         ocolor_r;
  logic signed [15:0]  odepth_r;

  logic signed [15:0] depth_mem [rpzp_pkg::PixelCount];

  // one row of the matrix: three 16x16 products, summed, shifted, wrapped
  function automatic logic signed [15:0] rot_row(input logic [47:0] c,
      input logic signed [15:0] x, input logic signed [15:0] y,
      input logic signed [15:0] z);
    logic signed [33:0] s;
    begin
      s = 34'(signed'(c[15:0])) * 34'(x) + 34'(signed'(c[31:16])) * 34'(y)
        + 34'(signed'(c[47:32])) * 34'(z);
      rot_row = 16'(s >>> rpzp_pkg::FractionBits);
    end
  endfunction

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      px_r    <= in_point_x;
      py_r    <= in_point_y;
      pz_r    <= in_point_z;
      color_r <= in_point_color;
    end
  end

  // rotation
  always_ff @(posedge clk) begin
    if (cmd.rot) begin
      rx_r <= rot_row(row_x, px_r, py_r, pz_r);
      ry_r <= rot_row(row_y, px_r, py_r, pz_r);
      rz_r <= rot_row(row_z, px_r, py_r, pz_r);
    end
  end

  // projection
  logic signed [16:0] pscale;
  logic signed [33:0] pxm, pym;
  assign pscale = 17'(rpzp_pkg::PerspBase) - 17'(rz_r);
  assign pxm = 34'(rx_r) * 34'(pscale);
  assign pym = 34'(ry_r) * 34'(pscale);
  always_ff @(posedge clk) begin
    if (cmd.proj) begin
      if (iso_mode) begin
        sx_r <= rx_r >>> 1;
        sy_r <= ry_r >>> 1;
      end else begin
        sx_r <= 16'(pxm >>> rpzp_pkg::PerspShift);
        sy_r <= 16'(pym >>> rpzp_pkg::PerspShift);
      end
    end
  end

  // screen position, bounds and linear address
  logic signed [17:0] col, row;
  assign col = 18'(rpzp_pkg::ScreenWidth / 2) + 18'(sx_r);
  assign row = 18'(rpzp_pkg::ScreenHeight / 2) + 18'(sy_r);
  always_ff @(posedge clk) begin
    if (cmd.place) begin
      onscr_r <= (col >= 0) && (col < 18'(rpzp_pkg::ScreenWidth)) &&
                 (row >= 0) && (row < 18'(rpzp_pkg::ScreenHeight));
      addr_r  <= AW'(row[8:0]) * AW'(rpzp_pkg::ScreenWidth) + AW'(col[8:0]);
    end
  end

  // depth memory: one write port, one registered read
  always_ff @(posedge clk) begin
    if (cmd.clr_step)
      depth_mem[clr_cnt_r] <= rpzp_pkg::DepthClear;
    else if (cmd.wr_test && onscr_r && (rz_r < mem_q_r))
      depth_mem[addr_r] <= rz_r;
    if (cmd.rd)
      mem_q_r <= depth_mem[addr_r];
  end

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_start) clr_cnt_r <= '0;
    else if (cmd.clr_step)       clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) ovld_r <= 1'b0;
    else if (cmd.wr_test && onscr_r && (rz_r < mem_q_r)) ovld_r <= 1'b1;
    else if (cmd.out_take) ovld_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.wr_test) begin
      oaddr_r  <= 17'(addr_r);
      ocolor_r <= color_r;
      odepth_r <= rz_r;
    end
  end

  assign sts.is_clear = (kind_r == rpzp_pkg::KIND_CLEAR);
  assign sts.clr_last = (clr_cnt_r == AW'(rpzp_pkg::PixelCount - 1));
  assign sts.out_full = ovld_r;
  assign out_valid         = ovld_r;
  assign out_pixel_address = oaddr_r;
  assign out_pixel_color   = ocolor_r;
  assign out_pixel_depth   = odepth_r;

  // a result address always lies on screen
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_address < 17'(rpzp_pkg::PixelCount)))
    else $error("pixel address off screen");
  // a write and a sweep never coincide
  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_step && cmd.wr_test)) else $error("sweep overlaps plot");
  // output word only ever loaded while empty or being taken
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_test |-> (!ovld_r || cmd.out_take)) else $error("output overwritten");
endmodule

// ===== rtl/rpzp_ctrl.sv =====
// Controller: sequences one word through the datapath, or runs the clear sweep
`timescale 1ns / 1ps
module rpzp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  output rpzp_pkg::rpzp_cmd_t  cmd,
  input  rpzp_pkg::rpzp_sts_t  sts
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROT   = 3'd1;
  localparam logic [2:0] S_PROJ  = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_TEST  = 3'd5;
  localparam logic [2:0] S_CLR   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       take;

  assign take = sts.out_full && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.out_take = take;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_ROT;
      end
      S_ROT: begin
        if (sts.is_clear) begin
          cmd.clr_start = 1'b1;
          state_nxt = S_CLR;
        end else begin
          cmd.rot = 1'b1;
          state_nxt = S_PROJ;
        end
      end
      S_PROJ:  begin cmd.proj = 1'b1;  state_nxt = S_PLACE; end
      S_PLACE: begin cmd.place = 1'b1; state_nxt = S_RD; end
      S_RD:    begin cmd.rd = 1'b1;    state_nxt = S_TEST; end
      S_TEST: begin
        // wait for an empty output register, or one being taken, before testing
        if (!sts.out_full || take) begin
          cmd.wr_test = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // accept only in idle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE)) else $error("ready outside idle");
  // the sweep ends in idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR && sts.clr_last) |=> (state_r == S_IDLE))
    else $error("sweep did not finish");
  // a test is always followed by idle
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_test |=> (state_r == S_IDLE)) else $error("test step stuck");
endmodule

// ===== rtl/rotate_project_zbuffer_plot.sv =====
// Top level: APB registers, controller and datapath of the z-buffered point plotter
//  channel  | dir | handshake                | fields
//  in_      | in  | in_valid / in_ready      | kind, point_x/y/z, point_color
//  out_     | out | out_valid / out_ready    | pixel_address, pixel_color, pixel_depth
//  cfg_     | in  | APB psel/penable/pwrite  | 4 registers, 64-bit data at 8*i
// A plot word passes through capture, rotate, project, place, depth read and test in turn.
// A clear word sweeps the 76800-entry depth memory, one entry per cycle.
// After reset the same sweep of the depth memory runs before the first word is taken.
// A stalled output holds the next plot in its test step until the word is taken.
`timescale 1ns / 1ps
module rotate_project_zbuffer_plot (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  input  logic signed [15:0] in_point_z,
  input  logic [15:0]        in_point_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [16:0]        out_pixel_address,
  output logic [15:0]        out_pixel_color,
  output logic signed [15:0] out_pixel_depth,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [63:0]        cfg_pwdata,
  output logic [63:0]        cfg_prdata,
  output logic               cfg_pready
);
  logic [47:0] row_x_r, row_y_r, row_z_r;
  logic        mode_r;
  logic [1:0]  ridx;
  rpzp_pkg::rpzp_cmd_t cmd;
  rpzp_pkg::rpzp_sts_t sts;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:3];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r <= 48'd16384;
      row_y_r <= 48'd16384 << 16;
      row_z_r <= 48'd16384 << 32;
      mode_r  <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (ridx)
        rpzp_pkg::REG_ROW_X: row_x_r <= cfg_pwdata[47:0];
        rpzp_pkg::REG_ROW_Y: row_y_r <= cfg_pwdata[47:0];
        rpzp_pkg::REG_ROW_Z: row_z_r <= cfg_pwdata[47:0];
        rpzp_pkg::REG_MODE:  mode_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (ridx)
      rpzp_pkg::REG_ROW_X: cfg_prdata = {16'd0, row_x_r};
      rpzp_pkg::REG_ROW_Y: cfg_prdata = {16'd0, row_y_r};
      rpzp_pkg::REG_ROW_Z: cfg_prdata = {16'd0, row_z_r};
      rpzp_pkg::REG_MODE:  cfg_prdata = {63'd0, mode_r};
      default:             cfg_prdata = '0;
    endcase
  end

  rpzp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  rpzp_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_kind(in_kind), .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_point_z(in_point_z), .in_point_color(in_point_color),
    .row_x(row_x_r), .row_y(row_y_r), .row_z(row_z_r), .iso_mode(mode_r),
    .out_valid(out_valid), .out_pixel_address(out_pixel_address),
    .out_pixel_color(out_pixel_color), .out_pixel_depth(out_pixel_depth)
  );
endmodule
